// ===== hw/rtl/bpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the bilinear particle deposit block.
// No dependencies; every other file but bpd_stream_if uses this package.
package bpd_pkg;

    localparam int GRID_X_DEF = 64;
    localparam int GRID_Y_DEF = 64;
    localparam int SUM_W      = 48;
    localparam int DATA_W     = 32;
    localparam int NODES_W    = 7;
    localparam int CELL_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 32;
    localparam int CORNERS    = 4;

    localparam logic [1:0] MODE_DEPOSIT  = 2'd0;
    localparam logic [1:0] MODE_READ     = 2'd1;
    localparam logic [1:0] MODE_READ_CLR = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES_Y  = 3'd5;

    localparam logic [DATA_W-1:0]  INV_RESET   = 32'h0001_0000;
    localparam logic [NODES_W-1:0] NODES_RESET = 7'd64;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] deposit_value;
        logic [CELL_W-1:0]        cell_x;
        logic [CELL_W-1:0]        cell_y;
    } bpd_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] cell_value;
        logic [1:0]              status;
    } bpd_result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_x;
        logic signed [DATA_W-1:0] origin_y;
        logic [DATA_W-1:0]        inv_spacing_x;
        logic [DATA_W-1:0]        inv_spacing_y;
        logic [NODES_W-1:0]       nodes_x;
        logic [NODES_W-1:0]       nodes_y;
    } bpd_cfg_t;

endpackage

// ===== hw/rtl/bpd_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload beat of type T.
// No dependencies; the payload type comes from bpd_pkg at instantiation.
interface bpd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bpd_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on bpd_pkg for default sizes only.
module bpd_ram #(
    parameter int WIDTH = bpd_pkg::SUM_W,
    parameter int DEPTH = bpd_pkg::GRID_X_DEF * bpd_pkg::GRID_Y_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/bpd_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file: origin, inverse spacing and node counts.
// Depends on bpd_pkg for register indexes, reset values and bpd_cfg_t.
module bpd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]  index,
    input  logic [bpd_pkg::CFG_W-1:0]      wdata,
    output bpd_pkg::bpd_cfg_t              cfg
);
    import bpd_pkg::*;

    bpd_cfg_t cfg_reg;
    bpd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (index)
                CFG_ORIGIN_X: cfg_next.origin_x      = wdata;
                CFG_ORIGIN_Y: cfg_next.origin_y      = wdata;
                CFG_INV_X:    cfg_next.inv_spacing_x = wdata;
                CFG_INV_Y:    cfg_next.inv_spacing_y = wdata;
                CFG_NODES_X:  cfg_next.nodes_x       = wdata[NODES_W-1:0];
                CFG_NODES_Y:  cfg_next.nodes_y       = wdata[NODES_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.inv_spacing_x <= INV_RESET;
            cfg_reg.inv_spacing_y <= INV_RESET;
            cfg_reg.nodes_x       <= NODES_RESET;
            cfg_reg.nodes_y       <= NODES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== hw/rtl/bpd_engine.sv =====
`timescale 1ns / 1ps
// Deposit/read sequencer: locates the cell, forms corner weights and does
// read-modify-write on the grid store. Depends on bpd_pkg and bpd_ram.
module bpd_engine #(
    parameter int GRID_X = bpd_pkg::GRID_X_DEF,
    parameter int GRID_Y = bpd_pkg::GRID_Y_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpd_pkg::bpd_cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bpd_pkg::bpd_item_t   in_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output bpd_pkg::bpd_result_t res_data
);
    import bpd_pkg::*;

    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int LXW   = ($clog2(GRID_X + 1) > NODES_W) ? $clog2(GRID_X + 1) : NODES_W;
    localparam int LYW   = ($clog2(GRID_Y + 1) > NODES_W) ? $clog2(GRID_Y + 1) : NODES_W;
    localparam int CW    = $clog2(CORNERS + 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_WGT   = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_RDW   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    bpd_item_t               item_reg;
    logic [63:0]             px_reg;
    logic [63:0]             py_reg;
    logic                    negx_reg;
    logic                    negy_reg;
    logic [32:0]             w_reg [CORNERS];
    logic [AW-1:0]           base_reg;
    logic [CW-1:0]           cnt_reg;
    logic signed [63:0]      prod_reg;
    logic [AW-1:0]           waddr_reg;
    logic                    pend_reg;
    logic                    sat_reg;
    logic [AW-1:0]           clr_reg;
    logic signed [SUM_W-1:0] res_value_reg;
    logic [1:0]              res_status_reg;

    logic [LXW-1:0]          lim_x;
    logic [LYW-1:0]          lim_y;
    logic signed [32:0]      dx;
    logic signed [32:0]      dy;
    logic [63:0]             px_mul;
    logic [63:0]             py_mul;
    logic [32:0]             cx1;
    logic [32:0]             cy1;
    logic                    dep_ok;
    logic                    rd_ok;
    logic [XW-1:0]           ix;
    logic [YW-1:0]           iy;
    logic [15:0]             fx;
    logic [15:0]             fy;
    logic [16:0]             wx0;
    logic [16:0]             wy0;
    logic [AW-1:0]           base;
    logic [AW-1:0]           corner;
    logic [AW-1:0]           cell_addr;
    logic                    issue;
    logic signed [65:0]      prod_full;
    logic signed [33:0]      rnd;
    logic signed [32:0]      share;
    logic signed [48:0]      sum49;
    logic                    ovf;
    logic [SUM_W-1:0]        sat_val;
    logic                    sat_any;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [SUM_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [SUM_W-1:0]        ram_rdata;

    bpd_ram #(
        .WIDTH(SUM_W),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        lim_x = (LXW'(cfg.nodes_x) < LXW'(GRID_X)) ? LXW'(cfg.nodes_x) : LXW'(GRID_X);
        lim_y = (LYW'(cfg.nodes_y) < LYW'(GRID_Y)) ? LYW'(cfg.nodes_y) : LYW'(GRID_Y);
    end

    assign dx     = 33'(item_reg.pos_x) - 33'(cfg.origin_x);
    assign dy     = 33'(item_reg.pos_y) - 33'(cfg.origin_y);
    assign px_mul = 64'(dx[31:0]) * 64'(cfg.inv_spacing_x);
    assign py_mul = 64'(dy[31:0]) * 64'(cfg.inv_spacing_y);

    assign cx1    = {1'b0, px_reg[63:32]} + 33'd1;
    assign cy1    = {1'b0, py_reg[63:32]} + 33'd1;
    assign dep_ok = !negx_reg && !negy_reg && (cx1 < 33'(lim_x)) && (cy1 < 33'(lim_y));
    assign rd_ok  = (LXW'(item_reg.cell_x) < lim_x) && (LYW'(item_reg.cell_y) < lim_y);

    assign ix   = px_reg[32 +: XW];
    assign iy   = py_reg[32 +: YW];
    assign fx   = px_reg[31:16];
    assign fy   = py_reg[31:16];
    assign wx0  = 17'h1_0000 - {1'b0, fx};
    assign wy0  = 17'h1_0000 - {1'b0, fy};
    assign base = AW'(32'(ix) * GRID_Y + 32'(iy));

    assign cell_addr = AW'(32'(item_reg.cell_x) * GRID_Y + 32'(item_reg.cell_y));
    assign corner    = base_reg + (cnt_reg[1] ? AW'(GRID_Y) : '0) + AW'(cnt_reg[0]);
    assign issue     = (cnt_reg < CW'(CORNERS));

    assign prod_full = 66'(item_reg.deposit_value) * 66'($signed({1'b0, w_reg[cnt_reg[1:0]]}));

    // share = floor((prod + 2^31) / 2^32)
    assign rnd     = $signed({prod_reg[63], prod_reg[63:31]}) + 34'sd1;
    assign share   = rnd[33:1];
    assign sum49   = $signed({ram_rdata[SUM_W-1], ram_rdata}) + $signed({{16{share[32]}}, share});
    assign ovf     = sum49[48] ^ sum49[47];
    assign sat_val = ovf ? (sum49[48] ? SUM_MIN : SUM_MAX) : sum49[SUM_W-1:0];
    assign sat_any = sat_reg || (pend_reg && ovf);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = waddr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = corner;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            S_ACC:
            begin
                ram_re    = issue;
                ram_we    = pend_reg;
                ram_wdata = sat_val;
            end
            S_RD:
            begin
                ram_re    = rd_ok;
                ram_raddr = cell_addr;
            end
            S_RDW:
            begin
                ram_we = (item_reg.mode == MODE_READ_CLR);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.mode)
                        MODE_DEPOSIT:  state_next = S_MUL;
                        MODE_READ:     state_next = S_RD;
                        MODE_READ_CLR: state_next = S_RD;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_MUL:   state_next = S_WGT;
            S_WGT:   state_next = dep_ok ? S_ACC : S_DONE;
            S_ACC:
            begin
                if (!issue)
                begin
                    state_next = S_DONE;
                end
            end
            S_RD:    state_next = rd_ok ? S_RDW : S_DONE;
            S_RDW:   state_next = S_DONE;
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == S_WGT)
            begin
                cnt_reg <= '0;
                sat_reg <= 1'b0;
            end
            else if (state_reg == S_ACC)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                sat_reg <= sat_any;
            end
            pend_reg <= (state_reg == S_ACC) && issue;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_reg       <= in_data;
                    res_value_reg  <= '0;
                    res_status_reg <= ST_OK;
                end
            end
            S_MUL:
            begin
                px_reg   <= px_mul;
                py_reg   <= py_mul;
                negx_reg <= dx[32];
                negy_reg <= dy[32];
            end
            S_WGT:
            begin
                w_reg[0] <= 33'(34'(wx0) * 34'(wy0));
                w_reg[1] <= 33'(34'(wx0) * 34'(fy));
                w_reg[2] <= 33'(34'(fx) * 34'(wy0));
                w_reg[3] <= 33'(34'(fx) * 34'(fy));
                base_reg <= base;
                if (!dep_ok)
                begin
                    res_status_reg <= ST_DROP;
                end
            end
            S_ACC:
            begin
                if (issue)
                begin
                    prod_reg  <= prod_full[63:0];
                    waddr_reg <= corner;
                end
                else
                begin
                    res_status_reg <= sat_any ? ST_SAT : ST_OK;
                end
            end
            S_RD:
            begin
                waddr_reg <= cell_addr;
                if (!rd_ok)
                begin
                    res_status_reg <= ST_DROP;
                end
            end
            S_RDW:
            begin
                res_value_reg <= ram_rdata;
            end
            default:
            begin
                res_value_reg <= res_value_reg;
            end
        endcase
    end

    assign in_ready            = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_DONE);
    assign res_data.cell_value = res_value_reg;
    assign res_data.status     = res_status_reg;
endmodule

// ===== hw/rtl/bilinear_particle_deposit.sv =====
`timescale 1ns / 1ps
// Top level of the cloud-in-cell deposit block: config registers, engine and
// result register. Depends on bpd_pkg, bpd_stream_if, bpd_cfg and bpd_engine.
//
//   channel  dir   handshake           payload
//   item     in    valid/ready         mode, pos_x, pos_y, deposit_value, cell_x, cell_y
//   result   out   valid/ready         cell_value, status
//   cfg      in    cfg_we (no stall)   cfg_index, cfg_wdata
//
// Deposit: each beat does a locate multiply, a weight multiply and four
// read-modify-writes on the single-port-pair grid RAM. Reads do one RAM read and
// read-clears also write zero; dropped deposits, bad reads and unused modes skip the RAM.
// After reset a clearing pass writes zero to all
// GRID_X*GRID_Y entries (4096 at the default size) before item goes ready.
// One item is in flight; the next is taken while a result waits in the output register.
module bilinear_particle_deposit #(
    parameter int GRID_X = bpd_pkg::GRID_X_DEF,
    parameter int GRID_Y = bpd_pkg::GRID_Y_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpd_pkg::CFG_W-1:0]     cfg_wdata,
    bpd_stream_if.sink                    item,
    bpd_stream_if.source                  result
);
    import bpd_pkg::*;

    bpd_cfg_t    cfg;
    logic        res_valid;
    logic        res_ready;
    bpd_result_t res_data;
    logic        out_valid_reg;
    bpd_result_t out_data_reg;

    bpd_cfg u_cfg (
        .clk  (clk),
        .rst_n(rst_n),
        .we   (cfg_we),
        .index(cfg_index),
        .wdata(cfg_wdata),
        .cfg  (cfg)
    );

    bpd_engine #(
        .GRID_X(GRID_X),
        .GRID_Y(GRID_Y)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .in_data  (item.data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data (res_data)
    );

    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
endmodule

// ===== hw/rtl/bpd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the deposit block, bound to the top level.
// Depends on bpd_pkg and bilinear_particle_deposit.
module bpd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_ready,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [bpd_pkg::SUM_W-1:0]  result_value,
    input logic [1:0]                 result_status
);
    import bpd_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_value) && $stable(result_status))
        else $error("result payload changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while previous beat still in work");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_status != ST_OK |-> result_value == '0)
        else $error("nonzero cell value on a drop or saturation result");
endmodule

bind bilinear_particle_deposit bpd_checker u_bpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_value (result.data.cell_value),
    .result_status(result.data.status)
);

// ===== sim/bilinear_particle_deposit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bilinear_particle_deposit: drives deposits and cell reads
// under random idling and checks each result beat against an in-bench grid mirror.
// Depends on bpd_pkg, bpd_stream_if and the bilinear_particle_deposit RTL.
module bilinear_particle_deposit_test;
    import bpd_pkg::*;

    localparam int GRID_X = GRID_X_DEF;
    localparam int GRID_Y = GRID_Y_DEF;
    localparam int CELLS = GRID_X * GRID_Y;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint SUM_HI = SUM_MAX;
    localparam longint SUM_LO = SUM_MIN;
    localparam int QUIET_LIMIT = 20000;
    localparam int MAX_REPORTS = 200;
    localparam int PHASE_ITEMS = 85;
    localparam int BURST_RUN = 40;
    localparam int TAIL_CYCLES = 20;

    class grid_mirror;
        longint grid_sum[CELLS];
        bpd_cfg_t regs;
        bpd_result_t awaited[$];
        int errors;

        function new();
            foreach (grid_sum[i])
                grid_sum[i] = 0;
            regs = '{32'sd0, 32'sd0, INV_RESET, INV_RESET, NODES_RESET, NODES_RESET};
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_ORIGIN_X: regs.origin_x = val;
                CFG_ORIGIN_Y: regs.origin_y = val;
                CFG_INV_X:    regs.inv_spacing_x = val;
                CFG_INV_Y:    regs.inv_spacing_y = val;
                CFG_NODES_X:  regs.nodes_x = val[NODES_W-1:0];
                CFG_NODES_Y:  regs.nodes_y = val[NODES_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned span(logic [NODES_W-1:0] n, int unsigned g);
            return (n < g) ? n : g;
        endfunction

        function bit locate(logic signed [DATA_W-1:0] pos, logic signed [DATA_W-1:0] org,
                            logic [DATA_W-1:0] inv, int unsigned lim,
                            output longint unsigned node, output logic [15:0] frac);
            longint d;
            longint unsigned p;
            node = 0;
            frac = '0;
            d = longint'(pos) - longint'(org);
            if (d < 0)
                return 1'b0;
            p = d;
            p = p * {32'd0, inv};
            node = p >> 32;
            frac = p[31:16];
            return (node + 1) < lim;
        endfunction

        function longint share(logic signed [DATA_W-1:0] v, longint w);
            longint prod;
            prod = longint'(v) * w;
            return (prod + 64'sh8000_0000) >>> 32;
        endfunction

        function bit accumulate(int unsigned idx, longint s);
            longint r;
            r = grid_sum[idx] + s;
            if (r > SUM_HI) begin
                grid_sum[idx] = SUM_HI;
                return 1'b1;
            end
            if (r < SUM_LO) begin
                grid_sum[idx] = SUM_LO;
                return 1'b1;
            end
            grid_sum[idx] = r;
            return 1'b0;
        endfunction

        function bpd_result_t predict(bpd_item_t it);
            bpd_result_t r;
            int unsigned lim_x, lim_y, base;
            longint unsigned ix, iy;
            logic [15:0] fx, fy;
            longint wx0, wy0, wx1, wy1;
            bit ok_x, ok_y, sat;
            r = '0;
            lim_x = span(regs.nodes_x, GRID_X);
            lim_y = span(regs.nodes_y, GRID_Y);
            case (it.mode)
                MODE_DEPOSIT: begin
                    ok_x = locate(it.pos_x, regs.origin_x, regs.inv_spacing_x, lim_x, ix, fx);
                    ok_y = locate(it.pos_y, regs.origin_y, regs.inv_spacing_y, lim_y, iy, fy);
                    if (!(ok_x && ok_y)) begin
                        r.status = ST_DROP;
                    end
                    else begin
                        wx1 = fx;
                        wy1 = fy;
                        wx0 = 65536 - wx1;
                        wy0 = 65536 - wy1;
                        base = ix * GRID_Y + iy;
                        sat = 1'b0;
                        sat |= accumulate(base, share(it.deposit_value, wx0 * wy0));
                        sat |= accumulate(base + 1, share(it.deposit_value, wx0 * wy1));
                        sat |= accumulate(base + GRID_Y, share(it.deposit_value, wx1 * wy0));
                        sat |= accumulate(base + GRID_Y + 1, share(it.deposit_value, wx1 * wy1));
                        r.status = sat ? ST_SAT : ST_OK;
                    end
                end
                MODE_READ, MODE_READ_CLR: begin
                    if (it.cell_x >= lim_x || it.cell_y >= lim_y) begin
                        r.status = ST_DROP;
                    end
                    else begin
                        base = it.cell_x * GRID_Y + it.cell_y;
                        r.cell_value = grid_sum[base][SUM_W-1:0];
                        if (it.mode == MODE_READ_CLR)
                            grid_sum[base] = 0;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void take_item(bpd_item_t it);
            awaited.push_back(predict(it));
        endfunction

        function void match_result(bpd_result_t got);
            bpd_result_t want;
            if (awaited.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $error("unexpected result beat: cell_value %0d status %0d",
                           got.cell_value, got.status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.cell_value !== want.cell_value) begin
                if (errors < MAX_REPORTS)
                    $error("cell_value: expected %0d, actual %0d",
                           want.cell_value, got.cell_value);
                errors++;
            end
            if (got.status !== want.status) begin
                if (errors < MAX_REPORTS)
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    bit src_gaps = 1'b1;
    bit snk_gaps = 1'b1;
    int quiet = 0;
    grid_mirror mirror = new();

    bpd_stream_if #(.T(bpd_item_t)) item_ch ();
    bpd_stream_if #(.T(bpd_result_t)) result_ch ();

    bilinear_particle_deposit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .item(item_ch.sink),
        .result(result_ch.source)
    );

    always #1 clk = ~clk;

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        result_ch.ready <= !(snk_gaps && $urandom_range(99) < 19);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            mirror.match_result(result_ch.data);
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("bilinear_particle_deposit_test: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        mirror.set_reg(idx, val);
    endtask

    task automatic apply_cfg(input bpd_cfg_t c);
        write_reg(CFG_ORIGIN_X, c.origin_x);
        write_reg(CFG_ORIGIN_Y, c.origin_y);
        write_reg(CFG_INV_X, c.inv_spacing_x);
        write_reg(CFG_INV_Y, c.inv_spacing_y);
        write_reg(CFG_NODES_X, CFG_W'(c.nodes_x));
        write_reg(CFG_NODES_Y, CFG_W'(c.nodes_y));
    endtask

    task automatic push_item(input bpd_item_t it);
        while (src_gaps && $urandom_range(99) < 19) begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.data = it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        mirror.take_item(it);
        @(negedge clk);
    endtask

    task automatic settle();
        item_ch.valid = 1'b0;
        while (mirror.awaited.size() != 0)
            @(negedge clk);
    endtask

    function automatic bpd_item_t mk_item(logic [1:0] mode, logic [DATA_W-1:0] px,
                                          logic [DATA_W-1:0] py, logic [DATA_W-1:0] v,
                                          logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy);
        bpd_item_t it;
        it.mode = mode;
        it.pos_x = px;
        it.pos_y = py;
        it.deposit_value = v;
        it.cell_x = cx;
        it.cell_y = cy;
        return it;
    endfunction

    // Aim a position at a random in-grid cell, fraction random or zero; random if inv is zero.
    function automatic logic [DATA_W-1:0] aim_axis(logic [DATA_W-1:0] org,
                                                   logic [DATA_W-1:0] inv, int unsigned lim);
        longint unsigned target, d;
        int unsigned c;
        logic [31:0] low;
        c = (lim >= 2) ? $urandom_range(lim - 2, 0) : 0;
        low = ($urandom_range(9) == 0) ? 32'd0 : $urandom();
        target = {c, low};
        if (inv == 0)
            d = $urandom();
        else
            d = target / {32'd0, inv};
        return org + d[31:0];
    endfunction

    function automatic bpd_item_t random_item();
        bpd_item_t it;
        int unsigned pick, lim_x, lim_y;
        lim_x = mirror.span(mirror.regs.nodes_x, GRID_X);
        lim_y = mirror.span(mirror.regs.nodes_y, GRID_Y);
        pick = $urandom_range(99);
        it.mode = (pick < 60) ? MODE_DEPOSIT : (pick < 78) ? MODE_READ :
                  (pick < 96) ? MODE_READ_CLR : MODE_UNUSED;
        it.pos_x = ($urandom_range(4) == 0) ? $urandom() :
                   aim_axis(mirror.regs.origin_x, mirror.regs.inv_spacing_x, lim_x);
        it.pos_y = ($urandom_range(4) == 0) ? $urandom() :
                   aim_axis(mirror.regs.origin_y, mirror.regs.inv_spacing_y, lim_y);
        pick = $urandom_range(9);
        if (pick < 6)
            it.deposit_value = $urandom();
        else if (pick < 8)
            it.deposit_value = $urandom_range(32'h0002_0000) - 32'h0001_0000;
        else if (pick == 8)
            it.deposit_value = 32'h7FFF_FFFF;
        else
            it.deposit_value = 32'h8000_0000;
        it.cell_x = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(lim_x - 1);
        it.cell_y = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(lim_y - 1);
        return it;
    endfunction

    initial
    begin
        bpd_cfg_t c;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        push_item(mk_item(MODE_DEPOSIT, 32'h0, 32'h0, 32'h7FFF_FFFF, 6'd0, 6'd0));
        push_item(mk_item(MODE_DEPOSIT, 32'h003E_8000, 32'h003E_8000, 32'h8000_0000,
                          6'd63, 6'd63));
        push_item(mk_item(MODE_DEPOSIT, 32'h0001_FFFF, 32'h0000_FFFF, 32'h1, 6'd0, 6'd0));
        push_item(mk_item(MODE_DEPOSIT, 32'h003F_0000, 32'h0, 32'h0001_0000, 6'd0, 6'd0));
        push_item(mk_item(MODE_DEPOSIT, 32'h0, 32'h003F_0000, 32'h0001_0000, 6'd0, 6'd0));
        push_item(mk_item(MODE_DEPOSIT, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 6'd0, 6'd0));
        push_item(mk_item(MODE_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                          6'd0, 6'd0));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd0, 6'd0));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd1, 6'd1));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd62, 6'd62));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd62, 6'd63));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd63, 6'd62));
        push_item(mk_item(MODE_READ_CLR, 32'h0, 32'h0, 32'h0, 6'd0, 6'd0));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd0, 6'd0));
        push_item(mk_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          6'd63, 6'd63));
        push_item(mk_item(MODE_READ_CLR, 32'h0, 32'h0, 32'h0, 6'd63, 6'd63));
        settle();

        // zero x spacing folds everything onto column 0; 2 x 2 node grid
        apply_cfg('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 7'd2, 7'd2});
        push_item(mk_item(MODE_DEPOSIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          6'd0, 6'd0));
        push_item(mk_item(MODE_DEPOSIT, 32'h0, 32'h7FFF_FFFE, 32'h0001_0000, 6'd0, 6'd0));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd1, 6'd1));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd2, 6'd0));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd0, 6'd63));
        push_item(mk_item(MODE_READ_CLR, 32'h0, 32'h0, 32'h0, 6'd0, 6'd0));
        settle();

        write_reg(CFG_NODES_X, CFG_W'(1));
        push_item(mk_item(MODE_DEPOSIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000,
                          6'd0, 6'd0));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd0, 6'd0));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd1, 6'd0));
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: c = '{32'sd0, 32'sd0, INV_RESET, INV_RESET, NODES_RESET, NODES_RESET};
                1: c = '{$urandom(), $urandom(), $urandom_range(1 << 20, 1 << 12),
                         $urandom_range(1 << 20, 1 << 12), $urandom_range(64, 2),
                         $urandom_range(64, 2)};
                2: c = '{32'sh8000_0000, 32'sh8000_0000, 32'h1, 32'h1, 7'd2, 7'd2};
                3: c = '{32'sh7FFF_FFFF, $urandom(), 32'hFFFF_FFFF,
                         $urandom_range(1 << 18, 1 << 14), 7'd64, 7'd3};
                4: c = '{$urandom(), $urandom(), $urandom(), $urandom(), 7'd127,
                         $urandom_range(64, 2)};
                default: c = '{$urandom(), $urandom(), $urandom_range(1 << 17, 1 << 15),
                               $urandom_range(1 << 17, 1 << 15), $urandom_range(8, 2),
                               $urandom_range(64, 33)};
            endcase
            apply_cfg(c);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2)
                    settle();
                push_item(random_item());
            end
            settle();
        end

        // hammer two nodes with full-scale values, back to back
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        apply_cfg('{32'sd0, 32'sd0, INV_RESET, INV_RESET, NODES_RESET, NODES_RESET});
        push_item(mk_item(MODE_READ_CLR, 32'h0, 32'h0, 32'h0, 6'd10, 6'd20));
        push_item(mk_item(MODE_READ_CLR, 32'h0, 32'h0, 32'h0, 6'd30, 6'd40));
        for (int i = 0; i < BURST_RUN; i++)
            push_item(mk_item(MODE_DEPOSIT, 32'h000A_0000, 32'h0014_0000, 32'h7FFF_FFFF,
                              6'd0, 6'd0));
        for (int i = 0; i < BURST_RUN; i++)
            push_item(mk_item(MODE_DEPOSIT, 32'h001E_0000, 32'h0028_0000, 32'h8000_0000,
                              6'd0, 6'd0));
        push_item(mk_item(MODE_READ_CLR, 32'h0, 32'h0, 32'h0, 6'd10, 6'd20));
        push_item(mk_item(MODE_READ_CLR, 32'h0, 32'h0, 32'h0, 6'd30, 6'd40));
        push_item(mk_item(MODE_READ, 32'h0, 32'h0, 32'h0, 6'd10, 6'd20));
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
        settle();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mirror.errors == 0 && mirror.awaited.size() == 0)
            $display("bilinear_particle_deposit_test: done, clean");
        else
            $display("bilinear_particle_deposit_test: done, errors");
        $finish;
    end
endmodule
